// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker in rvalu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/rvalu_pkg.sv
package rvalu_pkg;

   localparam int unsigned XLEN     = 64;
   localparam int unsigned NUM_REGS = 32;
   localparam int unsigned REG_AW   = $clog2(NUM_REGS);

   // Command codes on the request channel.
   localparam logic [1:0] CMD_EXEC  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Instruction encoding constants.
   localparam logic [6:0] OPC_IMM = 7'h13;
   localparam logic [6:0] OPC_REG = 7'h33;
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // Internal operation codes carried down the pipeline.
   typedef logic [2:0] op_type;
   localparam op_type OP_ADD     = 3'd0;
   localparam op_type OP_SUB     = 3'd1;
   localparam op_type OP_AND     = 3'd2;
   localparam op_type OP_OR      = 3'd3;
   localparam op_type OP_PASS    = 3'd4;
   localparam op_type OP_READ    = 3'd5;
   localparam op_type OP_ILLEGAL = 3'd6;
   localparam op_type OP_IGNORE  = 3'd7;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr_a;
      logic [REG_AW-1:0] addr_b;
   } rf_rd_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [XLEN-1:0]   data;
   } rf_wr_type;

endpackage

// File: rtl/core/rvalu_regfile.sv
module rvalu_regfile (
   input  logic                     clock,
   input  logic                     reset,
   input  rvalu_pkg::rf_rd_type     rd,
   input  rvalu_pkg::rf_wr_type     wr,
   output logic [rvalu_pkg::XLEN-1:0] data_a,
   output logic [rvalu_pkg::XLEN-1:0] data_b
);
   import rvalu_pkg::*;

   logic [XLEN-1:0]     mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [NUM_REGS-1:0] valid_in;
   logic [XLEN-1:0]     raw_a_ff, raw_b_ff, fwd_data_ff;
   logic                vld_a_ff, vld_b_ff, hit_a_ff, hit_b_ff;
   logic                wr_ok;

   // Entry 0 is never written, so its valid bit stays low and it reads zero.
   assign wr_ok = wr.en && (wr.addr != '0);

   always_comb begin
      valid_in = valid_ff;
      if (wr_ok) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // A read that coincides with a write to the same entry takes the new data
   // through the bypass, since the array returns the old contents.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         raw_a_ff    <= mem_ff[rd.addr_a];
         raw_b_ff    <= mem_ff[rd.addr_b];
         vld_a_ff    <= valid_ff[rd.addr_a];
         vld_b_ff    <= valid_ff[rd.addr_b];
         hit_a_ff    <= wr_ok && (wr.addr == rd.addr_a);
         hit_b_ff    <= wr_ok && (wr.addr == rd.addr_b);
         fwd_data_ff <= wr.data;
      end
   end

   assign data_a = hit_a_ff ? fwd_data_ff : (vld_a_ff ? raw_a_ff : '0);
   assign data_b = hit_b_ff ? fwd_data_ff : (vld_b_ff ? raw_b_ff : '0);

endmodule

// File: rtl/core/rv_alu_subset_executor.sv
// Executes a small RISC-V integer subset (ADDI, ADD, SUB, AND, OR) on a
// 32-entry, 64-bit register file, and lets the host write or read registers.
// Request channel: req_valid/req_ready carry one item made of req_command,
// req_instr_word, req_reg_select and req_write_value. Response channel:
// rsp_valid/rsp_ready carry one result item per request item, in order.
// An accepted item passes through the execute stage register into the output
// register, which drives rsp_valid. The block takes one item per cycle while
// the receiver is ready. The register file is a memory with two read ports and
// one write port, a registered read and a bypass from the write-back into the
// read data, so an instruction may use the register written by the one just
// before it.
// Reset clears the valid bit of every register, so all registers read zero
// afterwards; there is no clearing pass and the block is ready at once.
// When the receiver stalls, the result waits in the output register and one
// more item may be accepted into the execute stage; after that req_ready
// drops until the output register is taken. Writes to x0 are dropped and
// unsupported words report unknown_op with all other fields zero.
module rv_alu_subset_executor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_command,
   input  logic [31:0]                 req_instr_word,
   input  logic [rvalu_pkg::REG_AW-1:0] req_reg_select,
   input  logic [rvalu_pkg::XLEN-1:0]  req_write_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rvalu_pkg::REG_AW-1:0] rsp_dest_index,
   output logic [rvalu_pkg::XLEN-1:0]  rsp_dest_value,
   output logic                        rsp_did_write,
   output logic                        rsp_unknown_op
);
   import rvalu_pkg::*;

   // Decoded item held in the execute stage while the register file read
   // is in flight.
   typedef struct packed {
      op_type            op;
      logic [REG_AW-1:0] idx;
      logic              use_imm;
      logic [XLEN-1:0]   opb;
   } stage_type;

   stage_type s1_in, s1_ff;
   logic      s1_valid_ff, s1_valid_in;
   logic      accept, s1_fire, out_free;

   rf_rd_type rf_rd;
   rf_wr_type rf_wr;
   logic [XLEN-1:0] rf_a, rf_b;

   logic [REG_AW-1:0] rsp_idx_ff, rsp_idx_in;
   logic [XLEN-1:0]   rsp_val_ff, rsp_val_in;
   logic              rsp_wr_ff, rsp_wr_in, rsp_unk_ff, rsp_unk_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [6:0] opc, f7;
   logic [2:0] f3;
   logic [XLEN-1:0] op_b, alu_res;

   // The output register frees up when it is empty or being taken; the
   // execute stage can then move on, and a new item can enter behind it.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign opc = req_instr_word[6:0];
   assign f3  = req_instr_word[14:12];
   assign f7  = req_instr_word[31:25];

   // Decode and register file read address generation.
   always_comb begin
      s1_in.op      = OP_IGNORE;
      s1_in.idx     = '0;
      s1_in.use_imm = 1'b0;
      s1_in.opb     = req_write_value;
      rf_rd.en      = accept;
      rf_rd.addr_a  = req_reg_select;
      rf_rd.addr_b  = req_instr_word[24:20];
      unique case (req_command)
         CMD_EXEC: begin
            rf_rd.addr_a = req_instr_word[19:15];
            s1_in.idx    = req_instr_word[11:7];
            if (opc == OPC_IMM && f3 == F3_ADD) begin
               s1_in.op      = OP_ADD;
               s1_in.use_imm = 1'b1;
               s1_in.opb     = {{(XLEN-12){req_instr_word[31]}}, req_instr_word[31:20]};
            end else if (opc == OPC_REG && f3 == F3_ADD && f7 == F7_BASE) begin
               s1_in.op = OP_ADD;
            end else if (opc == OPC_REG && f3 == F3_ADD && f7 == F7_ALT) begin
               s1_in.op = OP_SUB;
            end else if (opc == OPC_REG && f3 == F3_AND && f7 == F7_BASE) begin
               s1_in.op = OP_AND;
            end else if (opc == OPC_REG && f3 == F3_OR && f7 == F7_BASE) begin
               s1_in.op = OP_OR;
            end else begin
               s1_in.op  = OP_ILLEGAL;
               s1_in.idx = '0;
            end
         end
         CMD_WRITE: begin
            s1_in.op      = OP_PASS;
            s1_in.idx     = req_reg_select;
            s1_in.use_imm = 1'b1;
         end
         CMD_READ: begin
            s1_in.op  = OP_READ;
            s1_in.idx = req_reg_select;
         end
         default: begin
            s1_in.op = OP_IGNORE;
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   rvalu_regfile u_regfile (
      .clock  (clock),
      .reset  (reset),
      .rd     (rf_rd),
      .wr     (rf_wr),
      .data_a (rf_a),
      .data_b (rf_b)
   );

   // Execute stage: 64-bit add, subtract, AND and OR, plus pass-through for host writes and reads.
   assign op_b = s1_ff.use_imm ? s1_ff.opb : rf_b;

   always_comb begin
      case (s1_ff.op)
         OP_ADD:  alu_res = rf_a + op_b;
         OP_SUB:  alu_res = rf_a - op_b;
         OP_AND:  alu_res = rf_a & op_b;
         OP_OR:   alu_res = rf_a | op_b;
         OP_PASS: alu_res = op_b;
         OP_READ: alu_res = rf_a;
         default: alu_res = '0;
      endcase
   end

   always_comb begin
      rsp_idx_in = s1_ff.idx;
      rsp_val_in = '0;
      rsp_wr_in  = 1'b0;
      rsp_unk_in = 1'b0;
      case (s1_ff.op) inside
         OP_ADD, OP_SUB, OP_AND, OP_OR, OP_PASS: begin
            if (s1_ff.idx != '0) begin
               rsp_val_in = alu_res;
               rsp_wr_in  = 1'b1;
            end
         end
         OP_READ: begin
            rsp_val_in = alu_res;
         end
         OP_ILLEGAL: begin
            rsp_idx_in = '0;
            rsp_unk_in = 1'b1;
         end
         default: begin
            rsp_idx_in = '0;
         end
      endcase
   end

   // Write-back happens on the same edge the result enters the output register.
   assign rf_wr.en   = s1_fire && rsp_wr_in;
   assign rf_wr.addr = s1_ff.idx;
   assign rf_wr.data = alu_res;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_idx_ff <= rsp_idx_in;
         rsp_val_ff <= rsp_val_in;
         rsp_wr_ff  <= rsp_wr_in;
         rsp_unk_ff <= rsp_unk_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_index = rsp_idx_ff;
   assign rsp_dest_value = rsp_val_ff;
   assign rsp_did_write  = rsp_wr_ff;
   assign rsp_unknown_op = rsp_unk_ff;

endmodule

// File: rtl/core/rvalu_checker.sv
`include "assert_macros.svh"

module rvalu_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [1:0]                   req_command,
   input logic [31:0]                  req_instr_word,
   input logic [rvalu_pkg::REG_AW-1:0] req_reg_select,
   input logic [rvalu_pkg::XLEN-1:0]   req_write_value,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rvalu_pkg::REG_AW-1:0] rsp_dest_index,
   input logic [rvalu_pkg::XLEN-1:0]   rsp_dest_value,
   input logic                         rsp_did_write,
   input logic                         rsp_unknown_op
);
   import rvalu_pkg::*;

   // A stalled result keeps its contents.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_value) && $stable(rsp_dest_index), "response changed while stalled")

   // Register x0 is never reported as written.
   `ASSERT_CLK(a_no_x0_write, clock, reset, rsp_valid && rsp_did_write |-> rsp_dest_index != '0, "write to x0 reported")

   // An unsupported word leaves every other field at zero.
   `ASSERT_CLK(a_unknown_clean, clock, reset, rsp_valid && rsp_unknown_op |-> !rsp_did_write && rsp_dest_index == '0 && rsp_dest_value == '0, "unknown op with nonzero fields")

   // With the receiver ready the block never refuses a new item.
   `ASSERT_CLK(a_full_rate, clock, reset, rsp_ready |-> req_ready, "request stalled while response side is ready")

   // Nothing is presented in the cycle after a reset edge.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind rv_alu_subset_executor rvalu_checker u_rvalu_checker (.*);

// File: tb/rv_alu_subset_executor_tb.sv
module rv_alu_subset_executor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rvalu_pkg::*;

   // The command code the block must ignore has no name in the package.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Encodings just outside the supported subset, used to provoke unknown_op.
   localparam logic [2:0] F3_SLL    = 3'd1;
   localparam logic [6:0] F7_MULDIV = 7'h01;

   localparam int HALF_PERIOD      = 10;
   localparam int RESET_CYCLES     = 12;
   localparam int RANDOM_ITEMS     = 1500;
   localparam int MAX_GAP          = 8;
   // Leaves room for any stray result to show up after the last expected one.
   localparam int SETTLE_CYCLES    = 10;
   // Longest correct quiet stretch is a sender gap plus a receiver stall plus
   // the pipeline latency; the limit is far beyond that.
   localparam int STALL_LIMIT      = 400;
   localparam int SHOWN_MISMATCHES = 10;

   typedef enum int {ALU_ADDI, ALU_ADD, ALU_SUB, ALU_AND, ALU_OR} alu_kind_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [31:0]       instr_word;
      logic [REG_AW-1:0] reg_select;
      logic [XLEN-1:0]   write_value;
   } req_item_type;

   typedef struct packed {
      logic [REG_AW-1:0] dest_index;
      logic [XLEN-1:0]   dest_value;
      logic              did_write;
      logic              unknown_op;
   } rsp_item_type;

   // One row of the directed part. When by_hand is set, want holds a result
   // typed in from the spec and it is used instead of the shadow prediction.
   typedef struct {
      req_item_type req;
      bit           by_hand;
      rsp_item_type want;
   } dir_row_type;

   // Every input carries a known value from time zero.
   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [1:0]          req_command     = CMD_EXEC;
   logic [31:0]         req_instr_word  = '0;
   logic [REG_AW-1:0]   req_reg_select  = '0;
   logic [XLEN-1:0]     req_write_value = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [REG_AW-1:0]   rsp_dest_index;
   logic [XLEN-1:0]     rsp_dest_value;
   logic                rsp_did_write;
   logic                rsp_unknown_op;

   // Shadow copy of the register file, advanced once per accepted item.
   logic [XLEN-1:0] shadow_gpr [NUM_REGS];
   // Results that accepted items still owe, oldest first.
   rsp_item_type    pending_wb [$];
   logic [4:0]      last_rd = '0;

   int unsigned sent_count      = 0;
   int unsigned results_checked = 0;
   int unsigned fail_count      = 0;
   int unsigned idle_cycles     = 0;
   int unsigned n_exec          = 0;
   int unsigned n_unknown       = 0;
   int unsigned n_write         = 0;
   int unsigned n_read          = 0;
   int unsigned n_unused        = 0;

   rv_alu_subset_executor dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_instr_word  (req_instr_word),
      .req_reg_select  (req_reg_select),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_dest_value  (rsp_dest_value),
      .rsp_did_write   (rsp_did_write),
      .rsp_unknown_op  (rsp_unknown_op)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic logic [31:0] r_type(logic [6:0] f7, logic [2:0] f3, logic [4:0] rs2,
                                          logic [4:0] rs1, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OPC_REG};
   endfunction

   function automatic logic [31:0] addi_word(logic [11:0] imm, logic [4:0] rs1, logic [4:0] rd);
      return {imm, rs1, F3_ADD, rd, OPC_IMM};
   endfunction

   function automatic req_item_type mk_req(logic [1:0] cmd, logic [31:0] word,
                                           logic [4:0] sel, logic [XLEN-1:0] value);
      return {cmd, word, sel, value};
   endfunction

   function automatic rsp_item_type mk_rsp(logic [4:0] idx, logic [XLEN-1:0] value, logic wr,
                                           logic unk);
      return {idx, value, wr, unk};
   endfunction

   function automatic dir_row_type checked_row(req_item_type r, rsp_item_type w);
      dir_row_type row;
      row.req     = r;
      row.by_hand = 1'b1;
      row.want    = w;
      return row;
   endfunction

   function automatic dir_row_type predicted_row(req_item_type r);
      dir_row_type row;
      row.req     = r;
      row.by_hand = 1'b0;
      row.want    = '0;
      return row;
   endfunction

   // Applies one item to the shadow register file and returns the result the
   // block owes for it. Unsupported words leave every register alone, and a
   // target of x0 is reported with a zero value and no write.
   function automatic rsp_item_type next_writeback(req_item_type r);
      rsp_item_type    o;
      logic [6:0]      opc;
      logic [6:0]      f7;
      logic [2:0]      f3;
      logic [4:0]      rd;
      logic [XLEN-1:0] a;
      logic [XLEN-1:0] b;
      logic [XLEN-1:0] v;
      logic            ok;
      o   = '0;
      opc = r.instr_word[6:0];
      rd  = r.instr_word[11:7];
      f3  = r.instr_word[14:12];
      f7  = r.instr_word[31:25];
      a   = shadow_gpr[r.instr_word[19:15]];
      b   = shadow_gpr[r.instr_word[24:20]];
      v   = '0;
      ok  = 1'b1;
      case (r.command)
         CMD_EXEC: begin
            if (opc == OPC_IMM && f3 == F3_ADD) begin
               // The upper seven bits belong to the immediate, so any value is legal.
               v = a + {{(XLEN-12){r.instr_word[31]}}, r.instr_word[31:20]};
            end else if (opc == OPC_REG && f3 == F3_ADD && f7 == F7_BASE) begin
               v = a + b;
            end else if (opc == OPC_REG && f3 == F3_ADD && f7 == F7_ALT) begin
               v = a - b;
            end else if (opc == OPC_REG && f3 == F3_AND && f7 == F7_BASE) begin
               v = a & b;
            end else if (opc == OPC_REG && f3 == F3_OR && f7 == F7_BASE) begin
               v = a | b;
            end else begin
               ok = 1'b0;
            end
            if (!ok) begin
               o.unknown_op = 1'b1;
            end else begin
               o.dest_index = rd;
               if (rd != 0) begin
                  shadow_gpr[rd] = v;
                  o.dest_value   = v;
                  o.did_write    = 1'b1;
               end
            end
         end
         CMD_WRITE: begin
            o.dest_index = r.reg_select;
            if (r.reg_select != 0) begin
               shadow_gpr[r.reg_select] = r.write_value;
               o.dest_value             = r.write_value;
               o.did_write              = 1'b1;
            end
         end
         CMD_READ: begin
            o.dest_index = r.reg_select;
            o.dest_value = shadow_gpr[r.reg_select];
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   // Gap before the next item on either side. The first stretch of every
   // span runs with no gaps at all, so back-to-back traffic is covered too.
   function automatic int unsigned draw_gap(int unsigned n, int unsigned span,
                                            int unsigned calm);
      if ((n % span) < calm) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [XLEN-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return {1'b1, {(XLEN-1){1'b0}}};
         3: return {1'b0, {(XLEN-1){1'b1}}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Registers are mostly drawn from a small window or from the last target,
   // so that results feed the next instruction as they would in real code.
   function automatic logic [4:0] pick_reg();
      case ($urandom_range(0, 9))
         0, 1, 2: return last_rd;
         3, 4, 5, 6: return 5'($urandom_range(0, 7));
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   // Most random items are well-formed ALU instructions with random operands;
   // the rest are near misses on the encoding, raw words, host writes and
   // reads, and the occasional unused command code.
   function automatic req_item_type random_item();
      req_item_type r;
      int unsigned  pick;
      alu_kind_type kind;
      logic [4:0]   rd;
      logic [4:0]   rs1;
      logic [4:0]   rs2;
      pick          = $urandom_range(0, 99);
      rd            = pick_reg();
      rs1           = pick_reg();
      rs2           = pick_reg();
      r.command     = CMD_EXEC;
      r.instr_word  = $urandom;
      r.reg_select  = 5'($urandom_range(0, 31));
      r.write_value = random_value();
      if (pick < 60) begin
         kind = alu_kind_type'($urandom_range(0, 4));
         case (kind)
            ALU_ADDI: r.instr_word = addi_word(12'($urandom), rs1, rd);
            ALU_ADD:  r.instr_word = r_type(F7_BASE, F3_ADD, rs2, rs1, rd);
            ALU_SUB:  r.instr_word = r_type(F7_ALT, F3_ADD, rs2, rs1, rd);
            ALU_AND:  r.instr_word = r_type(F7_BASE, F3_AND, rs2, rs1, rd);
            default:  r.instr_word = r_type(F7_BASE, F3_OR, rs2, rs1, rd);
         endcase
         last_rd = rd;
      end else if (pick < 68) begin
         r.instr_word = {7'($urandom), rs2, rs1, 3'($urandom), rd,
                         ($urandom_range(0, 1) != 0) ? OPC_REG : OPC_IMM};
      end else if (pick < 72) begin
         // A raw random word, almost always outside the subset.
      end else if (pick < 86) begin
         r.command    = CMD_WRITE;
         r.reg_select = rd;
         last_rd      = rd;
      end else if (pick < 97) begin
         r.command    = CMD_READ;
         r.reg_select = rs1;
      end else begin
         r.command = CMD_UNUSED;
      end
      return r;
   endfunction

   // Offers one item and returns at the edge that accepts it. Valid is only
   // lowered when a gap follows, so consecutive items can stream without a
   // bubble.
   task automatic push_item(req_item_type r, bit by_hand, rsp_item_type hand);
      int unsigned  gap;
      rsp_item_type model;
      gap = draw_gap(sent_count, 250, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= r.command;
      req_instr_word  <= r.instr_word;
      req_reg_select  <= r.reg_select;
      req_write_value <= r.write_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model = next_writeback(r);
      pending_wb.push_back(by_hand ? hand : model);
      sent_count++;
      case (r.command)
         CMD_EXEC: begin
            if (model.unknown_op) n_unknown++;
            else n_exec++;
         end
         CMD_WRITE: n_write++;
         CMD_READ:  n_read++;
         default:   n_unused++;
      endcase
   endtask

   // Holds the sender off until every owed result has come back.
   task automatic wait_all_retired();
      req_valid <= 1'b0;
      while (pending_wb.size() != 0) @(posedge clock);
   endtask

   // Sender: reset, the directed table, then the random stream.
   initial begin : req_side
      dir_row_type dir_table [$];
      foreach (shadow_gpr[i]) shadow_gpr[i] = '0;

      // Right after reset every register reads zero.
      dir_table.push_back(checked_row(mk_req(CMD_READ, 32'hFFFF_FFFF, 5'd5, '1),
                                      mk_rsp(5'd5, '0, 1'b0, 1'b0)));
      // Host writes at the extremes of the value and of the register number.
      dir_table.push_back(checked_row(mk_req(CMD_WRITE, '0, 5'd1, '1),
                                      mk_rsp(5'd1, '1, 1'b1, 1'b0)));
      dir_table.push_back(checked_row(mk_req(CMD_WRITE, '0, 5'd31, 64'h8000_0000_0000_0001),
                                      mk_rsp(5'd31, 64'h8000_0000_0000_0001, 1'b1, 1'b0)));
      // A host write to x0 is dropped, and x0 still reads zero.
      dir_table.push_back(checked_row(mk_req(CMD_WRITE, '0, 5'd0, 64'hDEAD_BEEF_0BAD_F00D),
                                      mk_rsp(5'd0, '0, 1'b0, 1'b0)));
      dir_table.push_back(checked_row(mk_req(CMD_READ, '0, 5'd0, '0),
                                      mk_rsp(5'd0, '0, 1'b0, 1'b0)));
      dir_table.push_back(checked_row(mk_req(CMD_READ, '0, 5'd31, '0),
                                      mk_rsp(5'd31, 64'h8000_0000_0000_0001, 1'b0, 1'b0)));
      // ADDI with the most negative and most positive immediates, and with
      // every bit of the upper immediate field set.
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC, addi_word(12'h800, 5'd1, 5'd2),
                                               5'd17, '1)));
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC, addi_word(12'h7FF, 5'd0, 5'd3),
                                               5'd0, '0)));
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC, addi_word(12'hFFF, 5'd31, 5'd4),
                                               5'd31, '1)));
      // Each register-register operation, with wrap-around on ADD and SUB.
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC,
                          r_type(F7_BASE, F3_ADD, 5'd31, 5'd1, 5'd5), '0, '0)));
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC,
                          r_type(F7_ALT, F3_ADD, 5'd1, 5'd0, 5'd6), '0, '0)));
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC,
                          r_type(F7_ALT, F3_ADD, 5'd1, 5'd31, 5'd7), '0, '0)));
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC,
                          r_type(F7_BASE, F3_AND, 5'd31, 5'd1, 5'd8), '0, '0)));
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC,
                          r_type(F7_BASE, F3_OR, 5'd3, 5'd2, 5'd9), '0, '0)));
      // Back-to-back use of the register written by the previous instruction.
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC,
                          r_type(F7_BASE, F3_ADD, 5'd9, 5'd9, 5'd10), '0, '0)));
      dir_table.push_back(predicted_row(mk_req(CMD_EXEC, addi_word(12'h001, 5'd10, 5'd11),
                                               '0, '0)));
      // Instructions that target x0 report no write.
      dir_table.push_back(checked_row(mk_req(CMD_EXEC, addi_word(12'h005, 5'd1, 5'd0), '0, '0),
                                      mk_rsp(5'd0, '0, 1'b0, 1'b0)));
      dir_table.push_back(checked_row(mk_req(CMD_EXEC,
                          r_type(F7_BASE, F3_OR, 5'd31, 5'd1, 5'd0), '0, '0),
                          mk_rsp(5'd0, '0, 1'b0, 1'b0)));
      // Unsupported words: wrong funct3 under OP-IMM, an M-extension funct7,
      // an alternate funct7 on OR, all ones and all zeros.
      dir_table.push_back(checked_row(mk_req(CMD_EXEC,
                          {7'h00, 5'd1, 5'd1, F3_SLL, 5'd3, OPC_IMM}, '0, '0),
                          mk_rsp(5'd0, '0, 1'b0, 1'b1)));
      dir_table.push_back(checked_row(mk_req(CMD_EXEC,
                          r_type(F7_MULDIV, F3_ADD, 5'd2, 5'd1, 5'd12), '0, '0),
                          mk_rsp(5'd0, '0, 1'b0, 1'b1)));
      dir_table.push_back(checked_row(mk_req(CMD_EXEC,
                          r_type(F7_ALT, F3_OR, 5'd2, 5'd1, 5'd13), '0, '0),
                          mk_rsp(5'd0, '0, 1'b0, 1'b1)));
      dir_table.push_back(checked_row(mk_req(CMD_EXEC, 32'hFFFF_FFFF, 5'd31, '1),
                                      mk_rsp(5'd0, '0, 1'b0, 1'b1)));
      dir_table.push_back(checked_row(mk_req(CMD_EXEC, 32'h0000_0000, 5'd0, '0),
                                      mk_rsp(5'd0, '0, 1'b0, 1'b1)));
      // The unused command code answers with an all-zero result.
      dir_table.push_back(checked_row(mk_req(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31, '1),
                                      mk_rsp(5'd0, '0, 1'b0, 1'b0)));
      // None of the rejected words above may have touched the file.
      dir_table.push_back(predicted_row(mk_req(CMD_READ, '0, 5'd12, '0)));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) push_item(dir_table[i].req, dir_table[i].by_hand, dir_table[i].want);
      wait_all_retired();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Halfway through, let the pipeline run completely dry once.
         if (i == RANDOM_ITEMS / 2) wait_all_retired();
         push_item(random_item(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_wb.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items: %0d executed, %0d unsupported words, %0d host writes, %0d reads,",
               sent_count, n_exec, n_unknown, n_write, n_read);
      $display("%0d unused command codes; %0d results checked, %0d mismatches.",
               n_unused, results_checked, fail_count);
      if (fail_count == 0 && pending_wb.size() == 0) begin
         $display("[rv_alu_subset_executor] OK");
      end else begin
         $display("[rv_alu_subset_executor] ERROR");
      end
      $finish;
   end

   // Receiver: stalls at random, takes one result per handshake and checks
   // every field against the oldest owed result.
   initial begin : rsp_side
      int unsigned  gap;
      rsp_item_type got;
      rsp_item_type want;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(results_checked, 300, 50);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = {rsp_dest_index, rsp_dest_value, rsp_did_write, rsp_unknown_op};
         if (pending_wb.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
               $display("%0t: result with nothing owed: index %0d value %h write %b unknown %b",
                        $realtime, got.dest_index, got.dest_value, got.did_write,
                        got.unknown_op);
         end else begin
            want = pending_wb.pop_front();
            if (got.dest_index !== want.dest_index || got.dest_value !== want.dest_value ||
                got.did_write !== want.did_write || got.unknown_op !== want.unknown_op) begin
               fail_count++;
               if (fail_count <= SHOWN_MISMATCHES)
                  $display({"%0t: result %0d: expected index %0d value %h write %b unknown %b,",
                            " got index %0d value %h write %b unknown %b"},
                           $realtime, results_checked, want.dest_index, want.dest_value,
                           want.did_write, want.unknown_op, got.dest_index, got.dest_value,
                           got.did_write, got.unknown_op);
            end
         end
         results_checked++;
      end
   end

   // Watchdog: a long run of cycles with no handshake on either side means
   // the block has hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == STALL_LIMIT) begin
         $display("No handshake for %0d cycles, %0d results still owed.",
                  STALL_LIMIT, pending_wb.size());
         $display("[rv_alu_subset_executor] ERROR");
         $finish;
      end
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rvalu_pkg.sv
rtl/core/rvalu_regfile.sv
rtl/core/rv_alu_subset_executor.sv
rtl/core/rvalu_checker.sv
tb/rv_alu_subset_executor_tb.sv
